// File: rtl/kbcs_pkg.sv
// Package: constants, types and key helpers for the bucket counting sort core
`default_nettype none
package kbcs_pkg;

  localparam int MAX_ENTRIES  = 1024;
  localparam int MAX_KEY_BITS = 10;
  localparam int ADDR_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W        = ADDR_W + 1;
  localparam int ENTRY_W      = 64;
  localparam int KEY_W        = MAX_KEY_BITS;

  // request codes
  localparam logic [2:0] REQ_LOAD   = 3'd0;
  localparam logic [2:0] REQ_SORT   = 3'd1;
  localparam logic [2:0] REQ_READ   = 3'd2;
  localparam logic [2:0] REQ_QUERY  = 3'd3;
  localparam logic [2:0] REQ_SEARCH = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_UNSORTED = 2'd2;
  localparam logic [1:0] ST_BAD      = 2'd3;

  // register indexes
  localparam logic [1:0] CFG_KEY_BITS   = 2'd0;
  localparam logic [1:0] CFG_ENTRY_BITS = 2'd1;
  localparam logic [1:0] CFG_KEEP_INDEX = 2'd2;

  typedef struct packed {
    logic [3:0] key_bits;
    logic [6:0] entry_bits;
    logic       keep_original_index;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [ENTRY_W-1:0] entry_out;
    logic [ADDR_W-1:0]  original_row;
    logic [CNT_W-1:0]   bucket_begin;
    logic [CNT_W-1:0]   bucket_size;
    logic               found;
    logic [CNT_W-1:0]   loaded_count;
  } res_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
  } mem_ctl_t;

  function automatic logic [ENTRY_W-1:0] width_mask(input logic [6:0] w);
    if (w >= 7'd64) return {ENTRY_W{1'b1}};
    return (64'd1 << w) - 64'd1;
  endfunction

  function automatic logic config_ok(input cfg_t c);
    logic ok;
    ok = (c.key_bits >= 4'd1) && (c.key_bits <= 4'(MAX_KEY_BITS)) &&
         (c.entry_bits >= 7'd1) && (c.entry_bits <= 7'd64) &&
         (c.entry_bits >= {3'b000, c.key_bits});
    return ok;
  endfunction

  // top key_bits bits of the entry; assumes a valid configuration
  function automatic logic [KEY_W-1:0] key_of(input logic [ENTRY_W-1:0] v, input cfg_t c);
    logic [6:0]         sh;
    logic [ENTRY_W-1:0] t;
    logic [ENTRY_W-1:0] km;
    sh = c.entry_bits - {3'b000, c.key_bits};
    t  = (v & width_mask(c.entry_bits)) >> sh;
    km = width_mask({3'b000, c.key_bits});
    return t[KEY_W-1:0] & km[KEY_W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/kbcs_ram.sv
// Generic simple dual-port RAM with registered read
`default_nettype none
module kbcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/kbcs_ctrl.sv
// Sequencer: request decode, sort passes and lookups over the shared memories
`default_nettype none
module kbcs_ctrl import kbcs_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         req_type,
  input  wire logic [ENTRY_W-1:0] entry_value,
  input  wire logic [ADDR_W-1:0]  row_position,
  input  wire logic [KEY_W-1:0]   bucket_key,
  input  wire cfg_t               cfg,
  input  wire logic               cfg_write,
  output logic                    res_valid,
  input  wire logic               res_take,
  output res_t                    res,
  output mem_ctl_t                load_ctl,
  output logic [ENTRY_W-1:0]      load_wdata,
  input  wire logic [ENTRY_W-1:0] load_rdata,
  output mem_ctl_t                sorted_ctl,
  output logic [ENTRY_W-1:0]      sorted_wdata,
  input  wire logic [ENTRY_W-1:0] sorted_rdata,
  output mem_ctl_t                origin_ctl,
  output logic [ADDR_W-1:0]       origin_wdata,
  input  wire logic [ADDR_W-1:0]  origin_rdata,
  output mem_ctl_t                start_ctl,
  output logic [CNT_W-1:0]        start_wdata,
  input  wire logic [CNT_W-1:0]   start_rdata,
  output mem_ctl_t                fill_ctl,
  output logic [CNT_W-1:0]        fill_wdata,
  input  wire logic [CNT_W-1:0]   fill_rdata
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_FIN   = 5'd1;
  localparam logic [4:0] S_CLR   = 5'd2;
  localparam logic [4:0] S_C_RD  = 5'd3;
  localparam logic [4:0] S_C_KEY = 5'd4;
  localparam logic [4:0] S_C_WR  = 5'd5;
  localparam logic [4:0] S_P_RD  = 5'd6;
  localparam logic [4:0] S_P_WR  = 5'd7;
  localparam logic [4:0] S_L_RD  = 5'd8;
  localparam logic [4:0] S_L_KEY = 5'd9;
  localparam logic [4:0] S_L_WR  = 5'd10;
  localparam logic [4:0] S_Q_A   = 5'd11;
  localparam logic [4:0] S_Q_B   = 5'd12;
  localparam logic [4:0] S_S_RD  = 5'd13;
  localparam logic [4:0] S_S_CMP = 5'd14;
  localparam logic [4:0] S_R_OUT = 5'd15;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_ENTRIES - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(MAX_ENTRIES);

  logic [4:0]         state;
  logic [CNT_W-1:0]   count;
  logic               sorted;
  logic [CNT_W-1:0]   idx;
  logic [CNT_W-1:0]   acc;
  logic [CNT_W-1:0]   beg_r;
  logic [CNT_W-1:0]   end_r;
  logic [KEY_W-1:0]   key_r;
  logic [2:0]         req_r;
  logic [ENTRY_W-1:0] val_r;
  logic [1:0]         r_status;
  logic [ENTRY_W-1:0] r_eout;
  logic [ADDR_W-1:0]  r_orow;
  logic [CNT_W-1:0]   r_beg;
  logic [CNT_W-1:0]   r_size;
  logic               r_found;

  logic               ok;
  logic [CNT_W-1:0]   count_eff;
  logic [KEY_W-1:0]   in_key;
  logic [KEY_W-1:0]   rd_key;
  logic [CNT_W-1:0]   q_end;
  logic [CNT_W-1:0]   pos;
  logic               key_in_range;

  assign ok           = config_ok(cfg);
  assign count_eff    = sorted ? '0 : count;
  assign in_key       = (req_type == REQ_QUERY) ? bucket_key : key_of(entry_value, cfg);
  assign rd_key       = key_of(load_rdata, cfg);
  assign q_end        = (key_r == LAST_ADDR) ? count : start_rdata;
  assign pos          = start_rdata + fill_rdata;
  assign key_in_range = {1'b0, bucket_key} < (CNT_W'(1) << cfg.key_bits);

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_FIN);
  assign res.status       = r_status;
  assign res.entry_out    = r_eout;
  assign res.original_row = r_orow;
  assign res.bucket_begin = r_beg;
  assign res.bucket_size  = r_size;
  assign res.found        = r_found;
  assign res.loaded_count = count;

  // memory port steering per sequencer step
  always_comb begin
    load_ctl     = '0;
    sorted_ctl   = '0;
    origin_ctl   = '0;
    start_ctl    = '0;
    fill_ctl     = '0;
    load_wdata   = entry_value & width_mask(cfg.entry_bits);
    sorted_wdata = val_r;
    origin_wdata = idx[ADDR_W-1:0];
    start_wdata  = acc;
    fill_wdata   = '0;
    unique case (state)
      S_IDLE: begin
        load_ctl.waddr   = count_eff[ADDR_W-1:0];
        load_ctl.we      = in_valid && (req_type == REQ_LOAD) && ok && (count_eff < FULL_CNT);
        sorted_ctl.raddr = row_position;
        origin_ctl.raddr = row_position;
        start_ctl.raddr  = in_key;
      end
      S_Q_A:   start_ctl.raddr = key_r + KEY_W'(1);
      S_CLR: begin
        fill_ctl.we    = 1'b1;
        fill_ctl.waddr = idx[ADDR_W-1:0];
      end
      S_C_RD:  load_ctl.raddr = idx[ADDR_W-1:0];
      S_C_KEY: fill_ctl.raddr = rd_key;
      S_C_WR: begin
        fill_ctl.we    = 1'b1;
        fill_ctl.waddr = key_r;
        fill_wdata     = fill_rdata + CNT_W'(1);
      end
      S_P_RD:  fill_ctl.raddr = idx[ADDR_W-1:0];
      S_P_WR: begin
        start_ctl.we    = 1'b1;
        start_ctl.waddr = idx[ADDR_W-1:0];
        fill_ctl.we     = 1'b1;
        fill_ctl.waddr  = idx[ADDR_W-1:0];
      end
      S_L_RD:  load_ctl.raddr = idx[ADDR_W-1:0];
      S_L_KEY: begin
        start_ctl.raddr = rd_key;
        fill_ctl.raddr  = rd_key;
      end
      S_L_WR: begin
        sorted_ctl.we    = 1'b1;
        sorted_ctl.waddr = pos[ADDR_W-1:0];
        origin_ctl.we    = cfg.keep_original_index;
        origin_ctl.waddr = pos[ADDR_W-1:0];
        fill_ctl.we      = 1'b1;
        fill_ctl.waddr   = key_r;
        fill_wdata       = fill_rdata + CNT_W'(1);
      end
      S_S_RD:  sorted_ctl.raddr = idx[ADDR_W-1:0];
      default: ;
    endcase
  end

  // sorted flag: config writes and new loads drop it, a finished sort sets it
  always_ff @(posedge clk) begin
    if (rst) begin
      sorted <= 1'b0;
    end else if (cfg_write) begin
      sorted <= 1'b0;
    end else if (state == S_L_RD && idx >= count) begin
      sorted <= 1'b1;
    end else if (state == S_IDLE && in_valid && req_type == REQ_LOAD && ok) begin
      sorted <= 1'b0;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) begin
          req_r    <= req_type;
          val_r    <= entry_value & width_mask(cfg.entry_bits);
          key_r    <= in_key;
          r_eout   <= '0;
          r_orow   <= '0;
          r_beg    <= '0;
          r_size   <= '0;
          r_found  <= 1'b0;
          case (req_type) inside
            REQ_LOAD: begin
              state <= S_FIN;
              if (!ok) r_status <= ST_BAD;
              else if (count_eff >= FULL_CNT) begin
                r_status <= ST_FULL;
                count    <= count_eff;
              end else begin
                r_status <= ST_OK;
                count    <= count_eff + CNT_W'(1);
              end
            end
            REQ_SORT: begin
              if (!ok) begin
                r_status <= ST_BAD;
                state    <= S_FIN;
              end else begin
                r_status <= ST_OK;
                idx      <= '0;
                state    <= S_CLR;
              end
            end
            REQ_READ: begin
              if (!sorted) begin
                r_status <= ST_UNSORTED;
                state    <= S_FIN;
              end else if ({1'b0, row_position} >= count) begin
                r_status <= ST_BAD;
                state    <= S_FIN;
              end else begin
                r_status <= ST_OK;
                state    <= S_R_OUT;
              end
            end
            REQ_QUERY, REQ_SEARCH: begin
              if (!sorted) begin
                r_status <= ST_UNSORTED;
                state    <= S_FIN;
              end else if (!ok) begin
                r_status <= ST_BAD;
                state    <= S_FIN;
              end else if (req_type == REQ_QUERY && !key_in_range) begin
                r_status <= ST_BAD;
                state    <= S_FIN;
              end else begin
                r_status <= ST_OK;
                state    <= S_Q_A;
              end
            end
            default: begin
              r_status <= ST_BAD;
              state    <= S_FIN;
            end
          endcase
        end
        S_FIN: if (res_take) state <= S_IDLE;
        // clear the per-bucket counters
        S_CLR: begin
          if (idx[ADDR_W-1:0] == LAST_ADDR) begin
            idx   <= '0;
            state <= S_C_RD;
          end else idx <= idx + CNT_W'(1);
        end
        // count entries per key
        S_C_RD: begin
          if (idx >= count) begin
            idx   <= '0;
            acc   <= '0;
            state <= S_P_RD;
          end else state <= S_C_KEY;
        end
        S_C_KEY: begin
          key_r <= rd_key;
          state <= S_C_WR;
        end
        S_C_WR: begin
          idx   <= idx + CNT_W'(1);
          state <= S_C_RD;
        end
        // prefix sum into the start table, counters back to zero
        S_P_RD: state <= S_P_WR;
        S_P_WR: begin
          acc <= acc + fill_rdata;
          if (idx[ADDR_W-1:0] == LAST_ADDR) begin
            idx   <= '0;
            state <= S_L_RD;
          end else begin
            idx   <= idx + CNT_W'(1);
            state <= S_P_RD;
          end
        end
        // stable placement
        S_L_RD: begin
          if (idx >= count) state <= S_FIN;
          else state <= S_L_KEY;
        end
        S_L_KEY: begin
          key_r <= rd_key;
          val_r <= load_rdata & width_mask(cfg.entry_bits);
          state <= S_L_WR;
        end
        S_L_WR: begin
          idx   <= idx + CNT_W'(1);
          state <= S_L_RD;
        end
        // bucket bounds
        S_Q_A: begin
          beg_r <= start_rdata;
          state <= S_Q_B;
        end
        S_Q_B: begin
          r_beg  <= beg_r;
          r_size <= q_end - beg_r;
          end_r  <= q_end;
          idx    <= beg_r;
          state  <= (req_r == REQ_SEARCH) ? S_S_RD : S_FIN;
        end
        // linear scan of the bucket
        S_S_RD: state <= (idx >= end_r) ? S_FIN : S_S_CMP;
        S_S_CMP: begin
          if (sorted_rdata == val_r) begin
            r_found <= 1'b1;
            state   <= S_FIN;
          end else begin
            idx   <= idx + CNT_W'(1);
            state <= S_S_RD;
          end
        end
        S_R_OUT: begin
          r_eout <= sorted_rdata;
          r_orow <= cfg.keep_original_index ? origin_rdata : '0;
          state  <= S_FIN;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/key_bucket_counting_sort_core.sv
// Top level: config registers, memories, sequencer and result register
//
//  channel | signals                                   | dir
//  in      | in_valid/in_ready, req_type..bucket_key   | to core
//  out     | out_valid/out_ready, status..loaded_count | from core
//  cfg     | cfg_we, cfg_index, cfg_wdata              | to core
//
// Search scans its bucket one entry at a time and stops at the first match.
// Sort steps: clear the bucket counters, count entries per key, prefix sum into the
// start table, then place each entry stably; each memory has a single read port.
// Synchronous reset clears control state; memories hold garbage until written.
// in_ready is low from acceptance until the result moves to the output register.
`default_nettype none
module key_bucket_counting_sort_core import kbcs_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         req_type,
  input  wire logic [ENTRY_W-1:0] entry_value,
  input  wire logic [ADDR_W-1:0]  row_position,
  input  wire logic [KEY_W-1:0]   bucket_key,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              status,
  output logic [ENTRY_W-1:0]      entry_out,
  output logic [ADDR_W-1:0]       original_row,
  output logic [CNT_W-1:0]        bucket_begin,
  output logic [CNT_W-1:0]        bucket_size,
  output logic                    found,
  output logic [CNT_W-1:0]        loaded_count,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [6:0]         cfg_wdata
);

  cfg_t               cfg;
  logic               cfg_write;
  logic               res_valid;
  logic               res_take;
  res_t               res;
  mem_ctl_t           load_ctl, sorted_ctl, origin_ctl, start_ctl, fill_ctl;
  logic [ENTRY_W-1:0] load_wdata, load_rdata, sorted_wdata, sorted_rdata;
  logic [ADDR_W-1:0]  origin_wdata, origin_rdata;
  logic [CNT_W-1:0]   start_wdata, start_rdata, fill_wdata, fill_rdata;

  assign cfg_write = cfg_we && (cfg_index == CFG_KEY_BITS || cfg_index == CFG_ENTRY_BITS ||
                                cfg_index == CFG_KEEP_INDEX);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.key_bits            <= 4'd7;
      cfg.entry_bits          <= 7'd16;
      cfg.keep_original_index <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KEY_BITS:   cfg.key_bits            <= cfg_wdata[3:0];
        CFG_ENTRY_BITS: cfg.entry_bits          <= cfg_wdata;
        CFG_KEEP_INDEX: cfg.keep_original_index <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  kbcs_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .req_type, .entry_value, .row_position, .bucket_key,
    .cfg, .cfg_write, .res_valid, .res_take, .res,
    .load_ctl, .load_wdata, .load_rdata,
    .sorted_ctl, .sorted_wdata, .sorted_rdata,
    .origin_ctl, .origin_wdata, .origin_rdata,
    .start_ctl, .start_wdata, .start_rdata,
    .fill_ctl, .fill_wdata, .fill_rdata
  );

  kbcs_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_ENTRIES)) u_load_ram (
    .clk, .we(load_ctl.we), .waddr(load_ctl.waddr), .wdata(load_wdata),
    .raddr(load_ctl.raddr), .rdata(load_rdata)
  );

  kbcs_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_ENTRIES)) u_sorted_ram (
    .clk, .we(sorted_ctl.we), .waddr(sorted_ctl.waddr), .wdata(sorted_wdata),
    .raddr(sorted_ctl.raddr), .rdata(sorted_rdata)
  );

  kbcs_ram #(.WIDTH(ADDR_W), .DEPTH(MAX_ENTRIES)) u_origin_ram (
    .clk, .we(origin_ctl.we), .waddr(origin_ctl.waddr), .wdata(origin_wdata),
    .raddr(origin_ctl.raddr), .rdata(origin_rdata)
  );

  kbcs_ram #(.WIDTH(CNT_W), .DEPTH(MAX_ENTRIES)) u_start_ram (
    .clk, .we(start_ctl.we), .waddr(start_ctl.waddr), .wdata(start_wdata),
    .raddr(start_ctl.raddr), .rdata(start_rdata)
  );

  kbcs_ram #(.WIDTH(CNT_W), .DEPTH(MAX_ENTRIES)) u_fill_ram (
    .clk, .we(fill_ctl.we), .waddr(fill_ctl.waddr), .wdata(fill_wdata),
    .raddr(fill_ctl.raddr), .rdata(fill_rdata)
  );

  // result register
  assign res_take = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      status       <= res.status;
      entry_out    <= res.entry_out;
      original_row <= res.original_row;
      bucket_begin <= res.bucket_begin;
      bucket_size  <= res.bucket_size;
      found        <= res.found;
      loaded_count <= res.loaded_count;
    end
  end

  // checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("core took a second item while busy");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> loaded_count <= CNT_W'(MAX_ENTRIES)) else $error("entry count overflow");

  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> entry_out == '0 && !found)
    else $error("failed request carries data");

endmodule
`default_nettype wire

// File: tb/sort_result_monitor.sv
// Result monitor: watches every channel, predicts each result and compares it
`timescale 1ns / 1ps
module sort_result_monitor import kbcs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [2:0]         req_type,
  input  logic [ENTRY_W-1:0] entry_value,
  input  logic [ADDR_W-1:0]  row_position,
  input  logic [KEY_W-1:0]   bucket_key,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [1:0]         status,
  input  logic [ENTRY_W-1:0] entry_out,
  input  logic [ADDR_W-1:0]  original_row,
  input  logic [CNT_W-1:0]   bucket_begin,
  input  logic [CNT_W-1:0]   bucket_size,
  input  logic               found,
  input  logic [CNT_W-1:0]   loaded_count,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [6:0]         cfg_wdata,
  output int                 fail_count,
  output int                 pending
);

  localparam int NUM_KEYS = 1 << MAX_KEY_BITS;

  // shadow copy of the block's registers and stores
  int                 key_w, ent_w;
  bit                 keep_row;
  logic [ENTRY_W-1:0] loaded_entries [MAX_ENTRIES];
  logic [ENTRY_W-1:0] sorted_entries [MAX_ENTRIES];
  int                 origin_rows    [MAX_ENTRIES];
  int                 bucket_starts  [NUM_KEYS+1];
  int                 bucket_counts  [NUM_KEYS];
  int                 list_len;
  bit                 list_sorted;
  res_t               expected_results[$];

  assign pending = expected_results.size();

  function automatic logic [ENTRY_W-1:0] low_ones(int w);
    if (w >= 64) return '1;
    return (64'd1 << w) - 64'd1;
  endfunction

  function automatic bit widths_legal();
    return key_w >= 1 && key_w <= MAX_KEY_BITS && ent_w >= 1 && ent_w <= 64 &&
           ent_w >= key_w;
  endfunction

  function automatic int bucket_of(logic [ENTRY_W-1:0] v);
    logic [ENTRY_W-1:0] t;
    t = ((v & low_ones(ent_w)) >> (ent_w - key_w)) & low_ones(key_w);
    return int'(t[KEY_W-1:0]);
  endfunction

  // counting pass, prefix table, then stable placement
  function automatic void counting_sort();
    int k, pos;
    for (int i = 0; i < NUM_KEYS; i++) bucket_counts[i] = 0;
    for (int i = 0; i < list_len; i++) bucket_counts[bucket_of(loaded_entries[i])]++;
    bucket_starts[0] = 0;
    for (int b = 0; b < NUM_KEYS; b++) begin
      bucket_starts[b+1] = bucket_starts[b] + ((b < (1 << key_w)) ? bucket_counts[b] : 0);
      bucket_counts[b] = 0;
    end
    for (int i = 0; i < list_len; i++) begin
      k = bucket_of(loaded_entries[i]);
      pos = bucket_starts[k] + bucket_counts[k];
      if (pos < MAX_ENTRIES) begin
        sorted_entries[pos] = loaded_entries[i] & low_ones(ent_w);
        if (keep_row) origin_rows[pos] = i;
      end
      bucket_counts[k]++;
    end
    list_sorted = 1;
  endfunction

  function automatic res_t sort_core_result(logic [2:0] req, logic [ENTRY_W-1:0] val,
                                            int row, int bkey);
    res_t r;
    int k, b, e;
    r = '0;
    case (req)
      REQ_LOAD: begin
        if (!widths_legal()) r.status = ST_BAD;
        else begin
          if (list_sorted) begin
            list_len = 0;
            list_sorted = 0;
          end
          if (list_len >= MAX_ENTRIES) r.status = ST_FULL;
          else begin
            loaded_entries[list_len] = val & low_ones(ent_w);
            list_len++;
          end
        end
      end
      REQ_SORT: begin
        if (!widths_legal()) r.status = ST_BAD;
        else counting_sort();
      end
      REQ_READ: begin
        if (!list_sorted) r.status = ST_UNSORTED;
        else if (row >= list_len) r.status = ST_BAD;
        else begin
          r.entry_out = sorted_entries[row];
          if (keep_row) r.original_row = ADDR_W'(origin_rows[row]);
        end
      end
      REQ_QUERY, REQ_SEARCH: begin
        if (!list_sorted) r.status = ST_UNSORTED;
        else if (!widths_legal()) r.status = ST_BAD;
        else if (req == REQ_QUERY && bkey >= (1 << key_w)) r.status = ST_BAD;
        else begin
          k = (req == REQ_QUERY) ? bkey : bucket_of(val);
          b = bucket_starts[k];
          e = bucket_starts[k+1];
          r.bucket_begin = CNT_W'(b);
          r.bucket_size = CNT_W'(e - b);
          if (req == REQ_SEARCH)
            for (int j = b; j < e && j < MAX_ENTRIES; j++)
              if (sorted_entries[j] == (val & low_ones(ent_w))) r.found = 1;
        end
      end
      default: r.status = ST_BAD;
    endcase
    r.loaded_count = CNT_W'(list_len);
    return r;
  endfunction

  task automatic compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      fail_count++;
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, exp_v, act_v);
    end
  endtask

  // track config writes, accepted items and accepted results
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      key_w = 7;
      ent_w = 16;
      keep_row = 0;
      list_len = 0;
      list_sorted = 0;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_KEY_BITS:   key_w = int'(cfg_wdata[3:0]);
          CFG_ENTRY_BITS: ent_w = int'(cfg_wdata);
          CFG_KEEP_INDEX: keep_row = cfg_wdata[0];
          default: ;
        endcase
        if (cfg_index == CFG_KEY_BITS || cfg_index == CFG_ENTRY_BITS ||
            cfg_index == CFG_KEEP_INDEX)
          list_sorted = 0;
      end
      if (in_valid && in_ready)
        expected_results.push_back(sort_core_result(req_type, entry_value,
                                                    int'(row_position), int'(bucket_key)));
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          $display("%0t: result with nothing expected, status %0d", $time, status);
        end else begin
          want = expected_results.pop_front();
          compare_field("status", 64'(want.status), 64'(status));
          compare_field("entry_out", want.entry_out, entry_out);
          compare_field("original_row", 64'(want.original_row), 64'(original_row));
          compare_field("bucket_begin", 64'(want.bucket_begin), 64'(bucket_begin));
          compare_field("bucket_size", 64'(want.bucket_size), 64'(bucket_size));
          compare_field("found", 64'(want.found), 64'(found));
          compare_field("loaded_count", 64'(want.loaded_count), 64'(loaded_count));
        end
      end
    end
  end

endmodule

// File: tb/tb_top.sv
// Testbench top: clock, reset, stimulus, output stalls, watchdog and verdict
`timescale 1ns / 1ps
module tb_top;
  import kbcs_pkg::*;

  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 60000;
  localparam int HOLD_CYCLES = 400;

  logic               clk, rst;
  logic               in_valid, in_ready, out_valid, out_ready;
  logic [2:0]         req_type;
  logic [ENTRY_W-1:0] entry_value, entry_out;
  logic [ADDR_W-1:0]  row_position, original_row;
  logic [KEY_W-1:0]   bucket_key;
  logic [1:0]         status;
  logic [CNT_W-1:0]   bucket_begin, bucket_size, loaded_count;
  logic               found;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [6:0]         cfg_wdata;
  int                 fail_count, pending;

  int idle_pct = 30;
  int hold_asks = 0;
  int items_sent = 0;
  int cur_kb = 7, cur_eb = 16;
  logic [ENTRY_W-1:0] list_vals[$];

  key_bucket_counting_sort_core DUT (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .entry_value(entry_value), .row_position(row_position),
    .bucket_key(bucket_key), .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .entry_out(entry_out), .original_row(original_row),
    .bucket_begin(bucket_begin), .bucket_size(bucket_size), .found(found),
    .loaded_count(loaded_count), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  sort_result_monitor u_monitor (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .entry_value(entry_value), .row_position(row_position),
    .bucket_key(bucket_key), .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .entry_out(entry_out), .original_row(original_row),
    .bucket_begin(bucket_begin), .bucket_size(bucket_size), .found(found),
    .loaded_count(loaded_count), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // receiver: random stalls plus requested long hold-offs
  initial begin
    int holds_done;
    holds_done = 0;
    out_ready = 0;
    forever begin
      @(negedge clk);
      if (holds_done != hold_asks) begin
        holds_done++;
        out_ready = 0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ready = ($urandom_range(99) >= idle_pct);
    end
  end

  // watchdog on cycles without any accepted item or result
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || rst) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // one item, held until accepted; called at a falling edge
  task automatic send(logic [2:0] req, logic [ENTRY_W-1:0] val, int row, int bkey);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_valid = 1;
    req_type = req;
    entry_value = val;
    row_position = ADDR_W'(row);
    bucket_key = KEY_W'(bkey);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid = 0;
    items_sent++;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [6:0] data);
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we = 1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 0;
  endtask

  // key width register also gets junk in its unused upper bits
  task automatic set_widths(int kb, int eb, bit keep);
    write_reg(CFG_KEY_BITS, 7'(kb) | 7'($urandom_range(7) << 4));
    write_reg(CFG_ENTRY_BITS, 7'(eb));
    write_reg(CFG_KEEP_INDEX, {6'($urandom), keep});
    cur_kb = kb;
    cur_eb = eb;
  endtask

  function automatic logic [ENTRY_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [ENTRY_W-1:0] search_value();
    logic [ENTRY_W-1:0] v;
    if (list_vals.size() > 0 && $urandom_range(99) < 60) begin
      v = list_vals[$urandom_range(list_vals.size() - 1)];
      if (cur_eb < 64) v = v | (rand64() << cur_eb);
      return v;
    end
    return rand64();
  endfunction

  // loads with duplicates, sort, then lookups; some noise mixed in
  task automatic load_sort_lookup(int n_loads, int n_looks);
    logic [ENTRY_W-1:0] v;
    int n;
    list_vals.delete();
    for (int i = 0; i < n_loads; i++) begin
      if ($urandom_range(99) < 8)
        send(3'($urandom_range(7)), rand64(), $urandom_range(1023), $urandom_range(1023));
      else begin
        v = (list_vals.size() > 0 && $urandom_range(99) < 35) ?
            list_vals[$urandom_range(list_vals.size() - 1)] : rand64();
        list_vals.push_back(v);
        send(REQ_LOAD, v, $urandom_range(1023), $urandom_range(1023));
      end
    end
    send(REQ_SORT, rand64(), $urandom_range(1023), $urandom_range(1023));
    if ($urandom_range(99) < 15) send(REQ_SORT, rand64(), 0, 0);
    n = list_vals.size();
    for (int i = 0; i < n_looks; i++)
      case ($urandom_range(2))
        0: send(REQ_READ, rand64(),
                ($urandom_range(99) < 85) ? $urandom_range(n) : $urandom_range(1023),
                $urandom_range(1023));
        1: send(REQ_QUERY, rand64(), $urandom_range(1023),
                ($urandom_range(99) < 85) ? $urandom_range((1 << cur_kb) - 1)
                                          : $urandom_range(1023));
        default: send(REQ_SEARCH, search_value(), $urandom_range(1023),
                      $urandom_range(1023));
      endcase
  endtask

  initial begin
    int phase;
    rst = 1;
    in_valid = 0;
    req_type = REQ_LOAD;
    entry_value = '0;
    row_position = '0;
    bucket_key = '0;
    cfg_we = 0;
    cfg_index = CFG_KEY_BITS;
    cfg_wdata = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: lookups before sort, unknown requests, empty sort, extremes
    send(REQ_READ, '0, 0, 0);
    send(REQ_QUERY, '0, 0, 0);
    send(REQ_SEARCH, '1, 0, 0);
    send(REQ_SEARCH + 3'd1, '1, 1023, 1023);
    send(REQ_SEARCH + 3'd2, '0, 0, 0);
    send(REQ_SEARCH + 3'd3, '1, 1023, 1023);
    send(REQ_SORT, '0, 0, 0);
    send(REQ_QUERY, '0, 0, 0);
    send(REQ_READ, '0, 0, 0);
    send(REQ_LOAD, '1, 1023, 1023);
    send(REQ_LOAD, '0, 0, 0);
    send(REQ_LOAD, 64'h0000_0000_0000_8001, 0, 0);
    send(REQ_SORT, '0, 0, 0);
    send(REQ_READ, '0, 0, 0);
    send(REQ_READ, '0, 2, 0);
    send(REQ_READ, '0, 3, 0);
    send(REQ_READ, '0, 1023, 0);
    send(REQ_QUERY, '0, 0, 127);
    send(REQ_QUERY, '0, 0, 128);
    send(REQ_QUERY, '0, 0, 1023);
    send(REQ_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0);
    send(REQ_SEARCH, 64'h0000_0000_0000_FFFE, 0, 0);
    send(REQ_LOAD, 64'h1234, 0, 0);
    send(REQ_READ, '0, 0, 0);

    // illegal width settings, then a stray write to the unused index
    set_widths(0, 16, 0);
    send(REQ_LOAD, rand64(), 0, 0);
    send(REQ_SORT, '0, 0, 0);
    set_widths(11, 16, 1);
    send(REQ_SORT, '0, 0, 0);
    send(REQ_QUERY, '0, 0, 0);
    set_widths(15, 127, 0);
    send(REQ_LOAD, rand64(), 0, 0);
    set_widths(5, 3, 0);
    send(REQ_SEARCH, rand64(), 0, 0);
    set_widths(4, 0, 1);
    send(REQ_LOAD, rand64(), 0, 0);
    set_widths(4, 65, 1);
    send(REQ_SORT, '0, 0, 0);
    set_widths(7, 16, 0);
    send(REQ_SORT, '0, 0, 0);
    write_reg(CFG_UNUSED, 7'($urandom));
    send(REQ_QUERY, '0, 0, 3);

    // full store, with a long receiver hold-off along the way
    set_widths(10, 64, 1);
    send(REQ_SORT, '0, 0, 0);
    for (int i = 0; i < 1026; i++) begin
      if (i == 300) hold_asks++;
      send(REQ_LOAD, rand64(), 0, 0);
    end
    send(REQ_SORT, '0, 0, 0);
    for (int i = 0; i < 10; i++) begin
      send(REQ_READ, '0, $urandom_range(1023), 0);
      send(REQ_QUERY, '0, 0, $urandom_range(1023));
    end

    // settings sweep, extremes first, then random ones
    phase = 0;
    while (items_sent < 1700) begin
      case (phase)
        0: set_widths(1, 1, 0);
        1: set_widths(10, 10, 1);
        2: set_widths(1, 64, 1);
        3: set_widths(10, 64, 0);
        4: set_widths(3, 3, 1);
        default: set_widths($urandom_range(1, 10), 0, $urandom_range(1));
      endcase
      if (phase > 4) begin
        cur_eb = $urandom_range(cur_kb, 64);
        write_reg(CFG_ENTRY_BITS, 7'(cur_eb));
      end
      idle_pct = (phase == 3) ? 0 : 30;
      if (phase == 6) hold_asks++;
      repeat (3) load_sort_lookup($urandom_range(0, 20), $urandom_range(4, 14));
      phase++;
    end
    idle_pct = 30;

    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
